>>> rtl/rmf_pkg.sv
package rmf_pkg;

    localparam int PERM_ENTRIES = 256;
    localparam int PERM_AW      = $clog2(PERM_ENTRIES);
    localparam int MAX_OCTAVES  = 16;
    localparam int OCT_W        = 5;
    localparam int MUL_W        = 33;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVES = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LACUN   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET  = 4'd3;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SMP,
        ST_F0, ST_F1, ST_F2, ST_F3,
        ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6,
        ST_GRAD,
        ST_B0, ST_B1, ST_B2, ST_B3, ST_B4, ST_B5, ST_B6, ST_B7, ST_B8,
        ST_R0, ST_R1, ST_R2, ST_R3, ST_R4, ST_R5, ST_R6,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [OCT_W-1:0] octaves;
        logic [15:0]      lacunarity;
        logic [15:0]      gain;
        logic [15:0]      offset_level;
    } t_cfg;

    typedef struct packed {
        logic               start;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_job;

    typedef struct packed {
        logic        idle;
        logic        res_valid;
        logic [31:0] height;
    } t_ctrl_out;

    typedef struct packed {
        logic               en;
        logic [PERM_AW-1:0] addr;
        logic [7:0]         data;
    } t_perm_wr;

    // improved noise gradient, 12 directions padded to 16
    function automatic logic signed [18:0] grad3(input logic [3:0] h,
                                                  input logic signed [17:0] x,
                                                  input logic signed [17:0] y,
                                                  input logic signed [17:0] z);
        logic signed [18:0] u;
        logic signed [18:0] v;
        u = (h < 4'd8) ? 19'(x) : 19'(y);
        if (h < 4'd4) begin
            v = 19'(y);
        end else if (h == 4'd12 || h == 4'd14) begin
            v = 19'(x);
        end else begin
            v = 19'(z);
        end
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

endpackage

>>> rtl/rmf_if.sv
interface rmf_in_if;
    import rmf_pkg::*;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [7:0]         table_index;
    logic [7:0]         table_value;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic signed [31:0] z_coord;
    modport source(output valid, opcode, table_index, table_value, x_coord, y_coord, z_coord,
                   input ready);
    modport sink(input valid, opcode, table_index, table_value, x_coord, y_coord, z_coord,
                 output ready);
endinterface

interface rmf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] height;
    modport source(output valid, height, input ready);
    modport sink(input valid, height, output ready);
endinterface

interface rmf_cfg_if;
    import rmf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/ridged_multifractal_noise.sv
// Ridged multifractal height from improved 3-D gradient noise. A load word writes one entry of
// the 256-entry permutation table; all entries that an evaluation touches must be loaded first.
// An evaluate word runs N octaves, N being the octave count capped at 16 (an octave count of
// zero runs no octave and answers with height 0). Each octave runs 46 steps on
// one shared 33x33 multiplier and the single read port of the permutation table: sampling and
// quintic fade per axis, six hash reads, eight corner gradient reads, seven blends, then ridge,
// weighting and the frequency and amplitude updates. The input is not ready while an evaluation
// runs; a finished height waits in an output register, so the next word can be taken meanwhile.
module ridged_multifractal_noise
    import rmf_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    rmf_in_if.sink          i_in,
    rmf_out_if.source       o_out,
    rmf_cfg_if.sink         i_cfg
);

    t_cfg                     r_cfg;
    t_job                     job;
    t_perm_wr                 perm_wr;
    t_ctrl_out                stat;
    logic                     in_acc;
    logic                     take;
    logic                     r_out_valid;
    logic [31:0]              r_out_height;
    logic signed [MUL_W-1:0]  ma, mb;
    logic signed [PROD_W-1:0] p;
    logic [PERM_AW-1:0]       rd_addr;
    logic [7:0]               rd_data;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.octaves      <= OCT_W'(4);
            r_cfg.lacunarity   <= 16'd8192;
            r_cfg.gain         <= 16'd2048;
            r_cfg.offset_level <= 16'd4096;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_OCTAVES: r_cfg.octaves      <= i_cfg.data[OCT_W-1:0];
                CFG_LACUN:   r_cfg.lacunarity   <= i_cfg.data;
                CFG_GAIN:    r_cfg.gain         <= i_cfg.data;
                CFG_OFFSET:  r_cfg.offset_level <= i_cfg.data;
                default:     ;
            endcase
        end
    end

    assign i_in.ready = stat.idle;
    assign in_acc     = i_in.valid && stat.idle;

    assign job.start = in_acc && (i_in.opcode == OP_EVAL);
    assign job.x     = i_in.x_coord;
    assign job.y     = i_in.y_coord;
    assign job.z     = i_in.z_coord;

    assign perm_wr.en   = in_acc && (i_in.opcode == OP_LOAD);
    assign perm_wr.addr = i_in.table_index;
    assign perm_wr.data = i_in.table_value;

    assign take = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= stat.res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && stat.res_valid) begin
            r_out_height <= stat.height;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.height = r_out_height;

    rmf_mul u_mul (
        .i_clk (i_clk),
        .i_a   (ma),
        .i_b   (mb),
        .o_p   (p)
    );

    rmf_perm u_perm (
        .i_clk     (i_clk),
        .i_wr      (perm_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    rmf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_job     (job),
        .i_take    (take),
        .i_p       (p),
        .i_rd_data (rd_data),
        .o_ma      (ma),
        .o_mb      (mb),
        .o_rd_addr (rd_addr),
        .o_stat    (stat)
    );

endmodule

>>> rtl/rmf_mul.sv
module rmf_mul
    import rmf_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_p
);

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

>>> rtl/rmf_perm.sv
module rmf_perm
    import rmf_pkg::*;
(
    input  logic               i_clk,
    input  t_perm_wr           i_wr,
    input  logic [PERM_AW-1:0] i_rd_addr,
    output logic [7:0]         o_rd_data
);

    logic [7:0] r_mem [PERM_ENTRIES];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/rmf_ctrl.sv
module rmf_ctrl
    import rmf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  t_job                     i_job,
    input  logic                     i_take,
    input  logic signed [PROD_W-1:0] i_p,
    input  logic [7:0]               i_rd_data,
    output logic signed [MUL_W-1:0]  o_ma,
    output logic signed [MUL_W-1:0]  o_mb,
    output logic [PERM_AW-1:0]       o_rd_addr,
    output t_ctrl_out                o_stat
);

    t_state r_state, n_state;
    logic [1:0]       r_axis, n_axis;
    logic [2:0]       r_corner, n_corner;
    logic [OCT_W-1:0] r_oct, n_oct;

    logic signed [31:0] r_pos [3];
    logic signed [31:0] n_pos [3];
    logic [7:0]         r_cell [3];
    logic [7:0]         n_cell [3];
    logic [15:0]        r_frac [3];
    logic [15:0]        n_frac [3];
    logic [16:0]        r_fade [3];
    logic [16:0]        n_fade [3];
    logic signed [18:0] r_g [8];
    logic signed [18:0] n_g [8];
    logic [19:0]        r_q16, n_q16;
    logic [7:0]         r_a, n_a, r_b, n_b, r_aa, n_aa, r_ab, n_ab, r_ba, n_ba, r_bb, n_bb;
    logic signed [19:0] r_l1, n_l1, r_l2, n_l2, r_h1, n_h1, r_h2, n_h2;
    logic signed [19:0] r_lo, n_lo, r_hi, n_hi, r_noise, n_noise;
    logic [31:0]        r_freq, n_freq, r_amp, n_amp;
    logic [25:0]        r_prev, n_prev;
    logic [3:0]         r_t1h, n_t1h;
    logic [63:0]        r_acc, n_acc, r_sum, n_sum;

    logic [OCT_W-1:0]   oct_lim;
    logic signed [20:0] sh;
    logic [35:0]        q32;
    logic [7:0]         rd_c1, rd_c2;
    logic signed [17:0] fx, fy, fz;
    logic [19:0]        n_abs;
    logic signed [21:0] rr;
    logic [20:0]        mm;

    function automatic logic [7:0] corner_addr(input logic [2:0] j, input logic [7:0] aa,
                                               input logic [7:0] ba, input logic [7:0] ab,
                                               input logic [7:0] bb);
        logic [7:0] base;
        case (j[1:0])
            2'd0:    base = aa;
            2'd1:    base = ba;
            2'd2:    base = ab;
            default: base = bb;
        endcase
        return base + {7'b0, j[2]};
    endfunction

    function automatic logic signed [MUL_W-1:0] sx21(input logic signed [20:0] d);
        return MUL_W'(d);
    endfunction

    assign oct_lim = (i_cfg.octaves > OCT_W'(MAX_OCTAVES)) ? OCT_W'(MAX_OCTAVES)
                                                           : i_cfg.octaves;
    assign sh    = i_p[36:16];
    assign q32   = 36'(i_p[31:0]) * 36'd6 + {4'd10, 32'b0}
                   - {r_frac[r_axis], 20'b0} + {4'b0, r_frac[r_axis], 16'b0};
    assign rd_c1 = i_rd_data + r_cell[1];
    assign rd_c2 = i_rd_data + r_cell[2];
    assign n_abs = r_noise[19] ? 20'(-r_noise) : 20'(r_noise);
    assign rr    = $signed({2'b0, i_cfg.offset_level, 4'b0}) - $signed({2'b0, n_abs});
    assign mm    = rr[21] ? 21'(-rr) : 21'(rr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_axis   <= '0;
            r_corner <= '0;
            r_oct    <= '0;
        end else begin
            r_state  <= n_state;
            r_axis   <= n_axis;
            r_corner <= n_corner;
            r_oct    <= n_oct;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_cell <= n_cell;
        r_frac <= n_frac;
        r_fade <= n_fade;
        r_g    <= n_g;
        r_q16  <= n_q16;
        r_a    <= n_a;
        r_b    <= n_b;
        r_aa   <= n_aa;
        r_ab   <= n_ab;
        r_ba   <= n_ba;
        r_bb   <= n_bb;
        r_l1   <= n_l1;
        r_l2   <= n_l2;
        r_h1   <= n_h1;
        r_h2   <= n_h2;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_noise <= n_noise;
        r_freq <= n_freq;
        r_amp  <= n_amp;
        r_prev <= n_prev;
        r_t1h  <= n_t1h;
        r_acc  <= n_acc;
        r_sum  <= n_sum;
    end

    always_comb begin
        n_state  = r_state;
        n_axis   = r_axis;
        n_corner = r_corner;
        n_oct    = r_oct;
        n_pos    = r_pos;
        n_cell   = r_cell;
        n_frac   = r_frac;
        n_fade   = r_fade;
        n_g      = r_g;
        n_q16    = r_q16;
        n_a      = r_a;
        n_b      = r_b;
        n_aa     = r_aa;
        n_ab     = r_ab;
        n_ba     = r_ba;
        n_bb     = r_bb;
        n_l1     = r_l1;
        n_l2     = r_l2;
        n_h1     = r_h1;
        n_h2     = r_h2;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_noise  = r_noise;
        n_freq   = r_freq;
        n_amp    = r_amp;
        n_prev   = r_prev;
        n_t1h    = r_t1h;
        n_acc    = r_acc;
        n_sum    = r_sum;
        o_ma      = '0;
        o_mb      = '0;
        o_rd_addr = '0;
        fx = $signed({2'b0, r_frac[0]}) - (r_corner[0] ? 18'sd65536 : 18'sd0);
        fy = $signed({2'b0, r_frac[1]}) - (r_corner[1] ? 18'sd65536 : 18'sd0);
        fz = $signed({2'b0, r_frac[2]}) - (r_corner[2] ? 18'sd65536 : 18'sd0);

        unique case (r_state)
            ST_IDLE: begin
                if (i_job.start) begin
                    n_pos[0] = i_job.x;
                    n_pos[1] = i_job.y;
                    n_pos[2] = i_job.z;
                    n_freq   = 32'd4096;
                    n_amp    = 32'd32768;
                    n_prev   = 26'd65536;
                    n_sum    = '0;
                    n_oct    = '0;
                    n_axis   = '0;
                    n_state  = (oct_lim == '0) ? ST_DONE : ST_SMP;
                end
            end
            ST_SMP: begin
                o_ma    = {r_pos[r_axis][31], r_pos[r_axis]};
                o_mb    = {1'b0, r_freq};
                n_state = ST_F0;
            end
            ST_F0: begin
                n_cell[r_axis] = i_p[35:28];
                n_frac[r_axis] = i_p[27:12];
                o_ma    = {17'b0, i_p[27:12]};
                o_mb    = {17'b0, i_p[27:12]};
                n_state = ST_F1;
            end
            ST_F1: begin
                n_q16   = q32[35:16];
                o_ma    = {1'b0, i_p[31:0]};
                o_mb    = {17'b0, r_frac[r_axis]};
                n_state = ST_F2;
            end
            ST_F2: begin
                o_ma    = {9'b0, i_p[47:24]};
                o_mb    = {13'b0, r_q16};
                n_state = ST_F3;
            end
            ST_F3: begin
                n_fade[r_axis] = i_p[40:24];
                if (r_axis == 2'd2) begin
                    n_axis  = '0;
                    n_state = ST_H0;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = ST_SMP;
                end
            end
            ST_H0: begin
                o_rd_addr = r_cell[0];
                n_state   = ST_H1;
            end
            ST_H1: begin
                n_a       = rd_c1;
                o_rd_addr = rd_c1;
                n_state   = ST_H2;
            end
            ST_H2: begin
                n_aa      = rd_c2;
                o_rd_addr = r_a + 8'd1;
                n_state   = ST_H3;
            end
            ST_H3: begin
                n_ab      = rd_c2;
                o_rd_addr = r_cell[0] + 8'd1;
                n_state   = ST_H4;
            end
            ST_H4: begin
                n_b       = rd_c1;
                o_rd_addr = rd_c1;
                n_state   = ST_H5;
            end
            ST_H5: begin
                n_ba      = rd_c2;
                o_rd_addr = r_b + 8'd1;
                n_state   = ST_H6;
            end
            ST_H6: begin
                n_bb      = rd_c2;
                o_rd_addr = r_aa;
                n_corner  = '0;
                n_state   = ST_GRAD;
            end
            ST_GRAD: begin
                n_g[r_corner] = grad3(i_rd_data[3:0], fx, fy, fz);
                o_rd_addr = corner_addr(r_corner + 3'd1, r_aa, r_ba, r_ab, r_bb);
                n_corner  = r_corner + 3'd1;
                if (r_corner == 3'd7) begin
                    n_state = ST_B0;
                end
            end
            ST_B0: begin
                o_ma    = {16'b0, r_fade[0]};
                o_mb    = sx21(21'(r_g[1]) - 21'(r_g[0]));
                n_state = ST_B1;
            end
            ST_B1: begin
                n_l1    = 20'(21'(r_g[0]) + sh);
                o_ma    = {16'b0, r_fade[0]};
                o_mb    = sx21(21'(r_g[3]) - 21'(r_g[2]));
                n_state = ST_B2;
            end
            ST_B2: begin
                n_l2    = 20'(21'(r_g[2]) + sh);
                o_ma    = {16'b0, r_fade[0]};
                o_mb    = sx21(21'(r_g[5]) - 21'(r_g[4]));
                n_state = ST_B3;
            end
            ST_B3: begin
                n_h1    = 20'(21'(r_g[4]) + sh);
                o_ma    = {16'b0, r_fade[0]};
                o_mb    = sx21(21'(r_g[7]) - 21'(r_g[6]));
                n_state = ST_B4;
            end
            ST_B4: begin
                n_h2    = 20'(21'(r_g[6]) + sh);
                o_ma    = {16'b0, r_fade[1]};
                o_mb    = sx21(21'(r_l2) - 21'(r_l1));
                n_state = ST_B5;
            end
            ST_B5: begin
                n_lo    = 20'(21'(r_l1) + sh);
                o_ma    = {16'b0, r_fade[1]};
                o_mb    = sx21(21'(r_h2) - 21'(r_h1));
                n_state = ST_B6;
            end
            ST_B6: begin
                n_hi    = 20'(21'(r_h1) + sh);
                n_state = ST_B7;
            end
            ST_B7: begin
                o_ma    = {16'b0, r_fade[2]};
                o_mb    = sx21(21'(r_hi) - 21'(r_lo));
                n_state = ST_B8;
            end
            ST_B8: begin
                n_noise = 20'(21'(r_lo) + sh);
                n_state = ST_R0;
            end
            ST_R0: begin
                o_ma    = {12'b0, mm};
                o_mb    = {12'b0, mm};
                n_state = ST_R1;
            end
            ST_R1: begin
                n_prev  = i_p[41:16];
                o_ma    = {7'b0, i_p[41:16]};
                o_mb    = {7'b0, r_prev};
                n_state = ST_R2;
            end
            ST_R2: begin
                n_t1h   = i_p[51:48];
                o_ma    = {1'b0, i_p[47:16]};
                o_mb    = {1'b0, r_amp};
                n_state = ST_R3;
            end
            ST_R3: begin
                n_acc   = i_p[63:0];
                o_ma    = {29'b0, r_t1h};
                o_mb    = {1'b0, r_amp};
                n_state = ST_R4;
            end
            ST_R4: begin
                n_acc   = r_acc + {i_p[31:0], 32'b0};
                o_ma    = {1'b0, r_freq};
                o_mb    = {17'b0, i_cfg.lacunarity};
                n_state = ST_R5;
            end
            ST_R5: begin
                n_sum   = r_sum + {16'b0, r_acc[63:16]};
                n_freq  = (i_p[47:44] != 4'd0) ? 32'hFFFF_FFFF : i_p[43:12];
                o_ma    = {1'b0, r_amp};
                o_mb    = {17'b0, i_cfg.gain};
                n_state = ST_R6;
            end
            ST_R6: begin
                n_amp  = (i_p[47:44] != 4'd0) ? 32'hFFFF_FFFF : i_p[43:12];
                n_axis = '0;
                if (r_oct + OCT_W'(1) >= oct_lim) begin
                    n_state = ST_DONE;
                end else begin
                    n_oct   = r_oct + OCT_W'(1);
                    n_state = ST_SMP;
                end
            end
            ST_DONE: begin
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_stat.idle      = (r_state == ST_IDLE);
    assign o_stat.res_valid = (r_state == ST_DONE);
    assign o_stat.height    = (r_sum > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r_sum[31:0];

`ifndef SYNTH
    ap_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_axis != 2'd3)
        else $error("axis counter out of range");

    ap_oct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oct < OCT_W'(MAX_OCTAVES))
        else $error("octave counter past limit");

    ap_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_job.start && r_state == ST_IDLE) |=> r_state != ST_IDLE)
        else $error("evaluate word not started");

    ap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !i_take) |=> (r_state == ST_DONE && $stable(r_sum)))
        else $error("result lost before handoff");
`endif

endmodule
